// File: hdl/ssq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
// Used by ssq_ctrl, ssq_datapath and stable_sorted_priority_queue; no dependencies.
package ssq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int PRIO_W   = 4;
  localparam int COUNT_W  = $clog2(DEPTH + 1);

  // Operation codes carried on the operation input.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic ins;
    logic pop;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// File: hdl/stable_sorted_priority_queue.sv
// Stable sorted priority queue, top level.
// Depends on ssq_pkg, ssq_ctrl and ssq_datapath.
//
// Usage:
//   A command is transferred at a rising edge where start is high and busy is low.
//   operation selects insert (priority_req, entry_tag) or pop of the head entry.
//   Entries are kept in ascending priority; equal priorities leave in arrival order.
//   Every command gives one result, shown for exactly one cycle with done high:
//   status (done, pop on empty, insert rejected as full), out_priority and out_tag
//   (the popped entry, zero otherwise) and occupancy after the command.
//   Latency: the result appears in the cycle after the transfer.
//   Throughput: one command per cycle; every slot compares against the new
//   priority in parallel, so an insert or pop needs no sequential search.
//   Reset (rst, synchronous) empties the queue; busy is high for the first cycle
//   after reset and low from then on.
//   The receiver cannot stall: each result must be taken in its strobe cycle.
module stable_sorted_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [ssq_pkg::PRIO_W-1:0]    priority_req,
  input  logic [ssq_pkg::TAG_BITS-1:0]  entry_tag,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [ssq_pkg::PRIO_W-1:0]    out_priority,
  output logic [ssq_pkg::TAG_BITS-1:0]  out_tag,
  output logic [ssq_pkg::COUNT_W-1:0]   occupancy
);
  import ssq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Command decode and result strobe.
  ssq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd),
    .busy      (busy),
    .done      (done),
    .status    (status)
  );

  // Sorted slot storage and result fields.
  ssq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .priority_req (priority_req),
    .entry_tag    (entry_tag),
    .dp_stat      (dp_stat),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .occupancy    (occupancy)
  );

endmodule

// File: hdl/ssq_ctrl.sv
// Controller of the stable sorted priority queue: accepts commands and decides the result status.
// Depends on ssq_pkg.
module ssq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  ssq_pkg::dp_stat_t dp_stat,
  output ssq_pkg::dp_cmd_t  dp_cmd,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status
);
  import ssq_pkg::*;

  typedef enum logic {
    S_INIT,
    S_READY
  } state_t;

  state_t  state;
  status_t status_next;

  // Decode an accepted transfer into a datapath command.
  always_comb begin
    dp_cmd.accept = start && (state == S_READY);
    dp_cmd.ins    = 1'b0;
    dp_cmd.pop    = 1'b0;
    status_next   = ST_DONE;
    unique case (op_t'(operation))
      OP_INSERT: begin
        if (dp_stat.full) begin
          status_next = ST_FULL;
        end else begin
          dp_cmd.ins = dp_cmd.accept;
        end
      end
      OP_POP: begin
        if (dp_stat.empty) begin
          status_next = ST_EMPTY;
        end else begin
          dp_cmd.pop = dp_cmd.accept;
        end
      end
      default: status_next = ST_DONE;
    endcase
  end

  assign busy = (state != S_READY);

  // State and registered result strobe and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      done   <= 1'b0;
      status <= ST_DONE;
    end else begin
      unique case (state)
        S_INIT:  state <= S_READY;
        S_READY: state <= S_READY;
        default: state <= S_INIT;
      endcase
      done <= dp_cmd.accept;
      if (dp_cmd.accept) begin
        status <= status_next;
      end
    end
  end

  // A result follows every accepted transfer and nothing else; insert and pop are never issued together.
  assert property (@(posedge clk) disable iff (rst) dp_cmd.accept |=> done)
    else $error("result strobe missing after accepted transfer");
  assert property (@(posedge clk) disable iff (rst) !dp_cmd.accept |=> !done)
    else $error("result strobe without accepted transfer");
  assert property (@(posedge clk) disable iff (rst) !(dp_cmd.ins && dp_cmd.pop))
    else $error("insert and pop issued together");

endmodule

// File: hdl/ssq_datapath.sv
// Datapath of the stable sorted priority queue: sorted slot registers, count and result fields.
// Depends on ssq_pkg.
module ssq_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  ssq_pkg::dp_cmd_t           dp_cmd,
  input  logic [ssq_pkg::PRIO_W-1:0] priority_req,
  input  logic [ssq_pkg::TAG_BITS-1:0] entry_tag,
  output ssq_pkg::dp_stat_t          dp_stat,
  output logic [ssq_pkg::PRIO_W-1:0] out_priority,
  output logic [ssq_pkg::TAG_BITS-1:0] out_tag,
  output logic [ssq_pkg::COUNT_W-1:0] occupancy
);
  import ssq_pkg::*;

  logic [PRIO_W-1:0]   slot_priority [DEPTH];
  logic [TAG_BITS-1:0] slot_tag      [DEPTH];
  logic [COUNT_W-1:0]  count;
  logic [DEPTH-1:0]    stay;

  // A slot stays put on insert when it is occupied and not above the new priority;
  // since the slots are sorted, these flags form a run from the head.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stay[i] = (COUNT_W'(i) < count) && (slot_priority[i] <= priority_req);
    end
  end

  assign dp_stat.empty = (count == '0);
  assign dp_stat.full  = (count == COUNT_W'(DEPTH));
  assign occupancy     = count;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.ins) begin
      count <= count + 1'b1;
    end else if (dp_cmd.pop) begin
      count <= count - 1'b1;
    end
  end

  // Slot array: shift down from the insert point, or shift up towards the head on pop.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (dp_cmd.ins && !stay[i]) begin
        if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
          slot_priority[i] <= priority_req;
          slot_tag[i]      <= entry_tag;
        end else begin
          slot_priority[i] <= slot_priority[(i == 0) ? 0 : i - 1];
          slot_tag[i]      <= slot_tag[(i == 0) ? 0 : i - 1];
        end
      end else if (dp_cmd.pop && i < DEPTH - 1) begin
        slot_priority[i] <= slot_priority[(i < DEPTH - 1) ? i + 1 : i];
        slot_tag[i]      <= slot_tag[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Result fields: the head entry on a successful pop, zero for any other transfer.
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      if (dp_cmd.pop) begin
        out_priority <= slot_priority[0];
        out_tag      <= slot_tag[0];
      end else begin
        out_priority <= '0;
        out_tag      <= '0;
      end
    end
  end

  // The count moves by one on each insert or pop and never passes the depth; a pop returns the former head tag.
  assert property (@(posedge clk) disable iff (rst) count <= COUNT_W'(DEPTH))
    else $error("occupancy beyond depth");
  assert property (@(posedge clk) disable iff (rst)
                   dp_cmd.ins |=> count == $past(count) + 1'b1)
    else $error("count not incremented on insert");
  assert property (@(posedge clk) disable iff (rst)
                   dp_cmd.pop |=> count == $past(count) - 1'b1)
    else $error("count not decremented on pop");
  assert property (@(posedge clk) disable iff (rst)
                   dp_cmd.pop |=> out_tag == $past(slot_tag[0]))
    else $error("popped tag is not the former head");

endmodule
